### hw/rtl/rlp_header_and_number_encoder_assert.svh
// Assertion macros for the RLP header and number encoder.
// Included by the top level; expects signals clk and rst_n in scope.
`ifndef RLP_HEADER_AND_NUMBER_ENCODER_ASSERT_SVH
`define RLP_HEADER_AND_NUMBER_ENCODER_ASSERT_SVH

// Checks that cond holds in the same cycle whenever trig holds.
`define RLP_ASSERT_SAME(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// Checks that cond holds in the cycle after trig holds.
`define RLP_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

### hw/rtl/rlp_enc_pkg.sv
// Package for the RLP header and number encoder: item types and constants.
// Used by rlp_enc_decode and rlp_header_and_number_encoder.
`default_nettype none

package rlp_enc_pkg;

    localparam logic [1:0] FUNC_STRING = 2'd0;
    localparam logic [1:0] FUNC_LIST   = 2'd1;
    localparam logic [1:0] FUNC_NUMBER = 2'd2;

    localparam logic [7:0] STR_SHORT_BASE  = 8'h80;
    localparam logic [7:0] STR_LONG_BASE   = 8'hb7;
    localparam logic [7:0] LIST_SHORT_BASE = 8'hc0;
    localparam logic [7:0] LIST_LONG_BASE  = 8'hf7;
    localparam logic [7:0] SINGLE_MAX      = 8'h7f;
    localparam logic [23:0] SHORT_LIMIT    = 24'd55;

    localparam int MAX_BYTES = 9;
    localparam int COUNT_W   = $clog2(MAX_BYTES + 1);

    typedef struct packed {
        logic [1:0]  func;
        logic [23:0] item_length;
        logic [7:0]  first_byte;
        logic [63:0] number_value;
    } req_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } rsp_item_t;

    typedef struct packed {
        logic [COUNT_W-1:0]           count;
        logic [MAX_BYTES-1:0][7:0]    bytes;
    } enc_bytes_t;

endpackage

`default_nettype wire

### hw/rtl/rlp_header_and_number_encoder.sv
// Top level of the RLP header and number encoder: input register, byte sequencer
// and output register. Depends on rlp_enc_pkg, rlp_enc_decode and the assert header.
`default_nettype none

// Each request item is encoded in one pass and then sent out one byte per cycle while
// rsp_stall does not hold the output, with last set on its final byte. A number item
// yields up to nine bytes; the next item is loaded in the cycle the previous one sends
// its final byte. The first byte of an item passes from the input register through the
// byte sequencer into the output register before it is valid.
module rlp_header_and_number_encoder
    import rlp_enc_pkg::*;
(
    input  wire        clk,
    input  wire        rst_n,
    input  req_item_t  req,
    input  wire        req_valid,
    output logic       req_stall,
    output rsp_item_t  rsp,
    output logic       rsp_valid,
    input  wire        rsp_stall
);

`include "rlp_header_and_number_encoder_assert.svh"

    logic                      item_valid_reg;
    req_item_t                 item_reg;
    enc_bytes_t                dec;
    logic [MAX_BYTES-1:0][7:0] bytes_reg;
    logic [MAX_BYTES-1:0][7:0] bytes_next;
    logic [COUNT_W-1:0]        rem_reg;
    logic [COUNT_W-1:0]        rem_next;
    logic                      rsp_valid_reg;
    rsp_item_t                 rsp_reg;
    logic                      out_free;
    logic                      emit;
    logic                      seq_load;

    rlp_enc_decode u_decode
    (
        .req (item_reg),
        .enc (dec)
    );

    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign emit      = (rem_reg != '0) && out_free;
    assign seq_load  = item_valid_reg &&
                       ((rem_reg == '0) || ((rem_reg == COUNT_W'(1)) && out_free));
    assign req_stall = item_valid_reg && !seq_load;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        bytes_next = bytes_reg;
        rem_next   = rem_reg;
        if (seq_load)
        begin
            bytes_next = dec.bytes;
            rem_next   = dec.count;
        end
        else if (emit)
        begin
            bytes_next = bytes_reg >> 8;
            rem_next   = rem_reg - COUNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            rem_reg        <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            if (!req_stall)
            begin
                item_valid_reg <= req_valid;
            end
            rem_reg <= rem_next;
            if (emit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!req_stall && req_valid)
        begin
            item_reg <= req;
        end
        bytes_reg <= bytes_next;
        if (emit)
        begin
            rsp_reg.out_byte <= bytes_reg[0];
            rsp_reg.last     <= (rem_reg == COUNT_W'(1));
        end
    end

    `RLP_ASSERT_SAME(a_rem_bound, 1'b1, rem_reg <= COUNT_W'(MAX_BYTES),
        "Byte count out of range.")
    `RLP_ASSERT_SAME(a_tail_pending, rsp_valid_reg && !rsp_reg.last, rem_reg != '0,
        "Item ended without a last byte.")
    `RLP_ASSERT_SAME(a_hold_item, item_valid_reg && (rem_reg > COUNT_W'(1)), req_stall,
        "New item taken while bytes remain.")
    `RLP_ASSERT_NEXT(a_last_drains, emit && (rem_reg == COUNT_W'(1)) && !seq_load,
        rem_reg == '0, "Sequencer did not drain after the last byte.")

endmodule

`default_nettype wire

### hw/rtl/rlp_enc_decode.sv
// Combinational encoder: turns one request item into its encoded bytes and count.
// Depends on rlp_enc_pkg.
`default_nettype none

module rlp_enc_decode
    import rlp_enc_pkg::*;
(
    input  req_item_t  req,
    output enc_bytes_t enc
);

    logic [1:0]  len_n;
    logic [4:0]  len_shamt;
    logic [23:0] len_al;
    logic [3:0]  num_n;
    logic [5:0]  num_shamt;
    logic [63:0] num_al;
    logic [2:0]  num_gap;
    logic [7:0]  short_base;
    logic [7:0]  long_base;
    logic        do_header;

    always_comb
    begin
        if (req.item_length[23:16] != 8'd0)
        begin
            len_n = 2'd3;
        end
        else if (req.item_length[15:8] != 8'd0)
        begin
            len_n = 2'd2;
        end
        else
        begin
            len_n = 2'd1;
        end
        len_shamt = {2'd3 - len_n, 3'b000};
        len_al    = req.item_length << len_shamt;

        num_n = 4'd1;
        for (int i = 1; i < 8; i++)
        begin
            if (req.number_value[8*i +: 8] != 8'd0)
            begin
                num_n = 4'(i + 1);
            end
        end
        num_gap   = 3'(4'd8 - num_n);
        num_shamt = {num_gap, 3'b000};
        num_al    = req.number_value << num_shamt;
    end

    always_comb
    begin
        enc        = '0;
        short_base = STR_SHORT_BASE;
        long_base  = STR_LONG_BASE;
        do_header  = 1'b0;

        unique case (req.func)
            FUNC_STRING:
            begin
                do_header = !(req.item_length == 24'd1 && req.first_byte <= SINGLE_MAX);
            end
            FUNC_LIST:
            begin
                short_base = LIST_SHORT_BASE;
                long_base  = LIST_LONG_BASE;
                do_header  = 1'b1;
            end
            FUNC_NUMBER:
            begin
                if (req.number_value == 64'd0)
                begin
                    enc.bytes[0] = STR_SHORT_BASE;
                    enc.count    = COUNT_W'(1);
                end
                else if (req.number_value <= 64'(SINGLE_MAX))
                begin
                    enc.bytes[0] = req.number_value[7:0];
                    enc.count    = COUNT_W'(1);
                end
                else
                begin
                    enc.bytes[0] = STR_SHORT_BASE + 8'(num_n);
                    for (int j = 1; j < 9; j++)
                    begin
                        enc.bytes[j] = num_al[63 - 8*(j-1) -: 8];
                    end
                    enc.count = COUNT_W'(num_n) + COUNT_W'(1);
                end
            end
            default:
            begin
                enc.count = '0;
            end
        endcase

        if (do_header)
        begin
            if (req.item_length <= SHORT_LIMIT)
            begin
                enc.bytes[0] = short_base + req.item_length[7:0];
                enc.count    = COUNT_W'(1);
            end
            else
            begin
                enc.bytes[0] = long_base + 8'(len_n);
                enc.bytes[1] = len_al[23:16];
                enc.bytes[2] = len_al[15:8];
                enc.bytes[3] = len_al[7:0];
                enc.count    = COUNT_W'(len_n) + COUNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire
